// ===== sv/sha1he_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1he_pkg
// Shared types, state codes and constants of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1he_pkg;

    // Input beat: packed message bytes.
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } in_t;

    // Output beat: one digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_digest;
    } out_t;

    // Round variables a through e.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } working_t;

    // Control of one round passed to the round unit.
    typedef struct packed {
        logic [6:0]  round;
        logic [31:0] w;
    } round_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT_RD,
        ST_OUT_CAP
    } state_t;

    localparam int CV_DEPTH  = 5;
    localparam int BUF_DEPTH = 16;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [3:0] LEN_HI_WORD = 4'd14;
    localparam logic [3:0] LEN_LO_WORD = 4'd15;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Initial chaining value word by index.
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 over a byte message with padding, length append and digest output.
// ----------------------------------------------------------------------------
//  Channel | Signals                           | Beat
//  input   | data_valid, data_ready, data      | up to four message bytes
//  output  | digest_valid, digest_ready, digest| one digest word, five per message
//
//  A non-final beat that does not fill a block leaves input ready; one that
//  fills a block loads the chaining value, runs 80 rounds and folds back.
//  A final beat writes padding to the end of each padding block, compresses
//  each block, then reads out the five digest words.
//  The rate is set by the one-round-per-cycle compression loop and the
//  single read port of the chaining value RAM.
//  Reset is asynchronous and active low; no clearing pass is needed.
//  A stalled digest word holds in the output register; input resumes only after the fifth word is captured.
// ----------------------------------------------------------------------------
module sha1_hash_engine
    import sha1he_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic data_valid,
    output logic data_ready,
    input  in_t  data,
    output logic digest_valid,
    input  logic digest_ready,
    output out_t digest
);

    state_t      state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  t_reg, t_next;
    logic [60:0] total_reg, total_next;
    logic [31:0] cur_reg, cur_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  ptr_reg, ptr_next;
    logic        first_reg, first_next;
    logic        len_here_reg, len_here_next;
    logic        final_reg, final_next;
    logic        pad_reg, pad_next;
    logic        last_pend_reg, last_pend_next;
    logic        init_reg, init_next;
    working_t    vars_reg, vars_next;
    logic [31:0] sched_reg [16];
    logic        sched_push;
    logic [31:0] sched_w;
    out_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  cv_raddr_q_reg;

    // Memory ports.
    logic        buf_we;
    logic [3:0]  buf_waddr, buf_raddr;
    logic [31:0] buf_wdata, buf_rdata;
    logic        cv_we;
    logic [2:0]  cv_waddr, cv_raddr;
    logic [31:0] cv_wdata, cv_rdata, cv_rdata_eff;

    // Absorb datapath.
    logic [2:0]  n_bytes;
    logic [1:0]  lane;
    logic [31:0] byte_mask;
    logic [63:0] shifted, combined;
    logic [2:0]  fill_sum;
    logic [60:0] total_sum;
    logic        accept;

    round_ctl_t  rctl;
    working_t    vars_round;

    sha1he_ram #(.WIDTH(32), .DEPTH(BUF_DEPTH)) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    sha1he_ram #(.WIDTH(32), .DEPTH(CV_DEPTH)) u_cv (
        .clk   (clk),
        .we    (cv_we),
        .waddr (cv_waddr),
        .wdata (cv_wdata),
        .raddr (cv_raddr),
        .rdata (cv_rdata)
    );

    sha1he_round u_round (
        .vars     (vars_reg),
        .ctl      (rctl),
        .vars_new (vars_round)
    );

    // Chaining value reads as the initial value until the first fold of each message.
    assign cv_rdata_eff = init_reg ? init_hash(cv_raddr_q_reg) : cv_rdata;

    // Byte merge of a new beat into the partial word.
    always_comb
    begin
        n_bytes = (data.byte_count > 3'd4) ? 3'd4 : data.byte_count;
        lane    = total_reg[1:0];
        case (n_bytes)
            3'd0:    byte_mask = 32'h00000000;
            3'd1:    byte_mask = 32'hFF000000;
            3'd2:    byte_mask = 32'hFFFF0000;
            3'd3:    byte_mask = 32'hFFFFFF00;
            default: byte_mask = 32'hFFFFFFFF;
        endcase
        shifted   = {data.data_word & byte_mask, 32'h0} >> {lane, 3'b000};
        combined  = {cur_reg, 32'h0} | shifted;
        fill_sum  = {1'b0, lane} + n_bytes;
        total_sum = total_reg + 61'(n_bytes);
    end

    assign accept     = data_valid && data_ready;
    assign data_ready = (state_reg == ST_IDLE);

    // Message schedule word for the current round.
    always_comb
    begin
        if (t_reg < 7'd16)
        begin
            sched_w = buf_rdata;
        end
        else
        begin
            sched_w = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
            sched_w = {sched_w[30:0], sched_w[31]};
        end
        rctl.round = t_reg;
        rctl.w     = sched_w;
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        t_next         = t_reg;
        total_next     = total_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        len_here_next  = len_here_reg;
        final_next     = final_reg;
        pad_next       = pad_reg;
        last_pend_next = last_pend_reg;
        init_next      = init_reg;
        vars_next      = vars_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        sched_push     = 1'b0;
        buf_we         = 1'b0;
        buf_waddr      = ptr_reg;
        buf_wdata      = 32'h0;
        buf_raddr      = 4'd0;
        cv_we          = 1'b0;
        cv_waddr       = cnt_reg - 3'd1;
        cv_wdata       = cv_rdata_eff + vars_reg.a;
        cv_raddr       = cnt_reg;

        if (digest_valid && digest_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    total_next     = total_sum;
                    len_next       = {total_sum, 3'b000};
                    last_pend_next = data.last_word;
                    buf_waddr      = total_reg[5:2];
                    buf_wdata      = combined[63:32];
                    if (fill_sum >= 3'd4)
                    begin
                        buf_we   = 1'b1;
                        cur_next = combined[31:0];
                    end
                    else
                    begin
                        cur_next = combined[63:32];
                    end
                    if (fill_sum >= 3'd4 && total_reg[5:2] == LEN_LO_WORD)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = 3'd0;
                    end
                    else if (data.last_word)
                    begin
                        state_next    = ST_PAD;
                        pad_next      = 1'b1;
                        first_next    = 1'b1;
                        ptr_next      = total_sum[5:2];
                        len_here_next = (total_sum[5:2] < LEN_HI_WORD);
                    end
                end
            end

            ST_PAD:
            begin
                buf_we = 1'b1;
                if (first_reg)
                begin
                    buf_wdata = cur_reg | (32'h80000000 >> {lane, 3'b000});
                end
                else if (len_here_reg && ptr_reg == LEN_HI_WORD)
                begin
                    buf_wdata = len_reg[63:32];
                end
                else if (len_here_reg && ptr_reg == LEN_LO_WORD)
                begin
                    buf_wdata = len_reg[31:0];
                end
                first_next = 1'b0;
                if (ptr_reg == LEN_LO_WORD)
                begin
                    state_next = ST_LOAD;
                    cnt_next   = 3'd0;
                    final_next = len_here_reg;
                end
                else
                begin
                    ptr_next = ptr_reg + 4'd1;
                end
            end

            ST_LOAD:
            begin
                if (cnt_reg != 3'd0)
                begin
                    vars_next = {vars_reg.b, vars_reg.c, vars_reg.d, vars_reg.e,
                                 cv_rdata_eff};
                end
                if (cnt_reg == 3'(CV_DEPTH))
                begin
                    state_next = ST_ROUND;
                    t_next     = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            ST_ROUND:
            begin
                buf_raddr  = t_reg[3:0] + 4'd1;
                sched_push = 1'b1;
                vars_next  = vars_round;
                if (t_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                    cnt_next   = 3'd0;
                end
                else
                begin
                    t_next = t_reg + 7'd1;
                end
            end

            ST_FOLD:
            begin
                if (cnt_reg != 3'd0)
                begin
                    cv_we     = 1'b1;
                    vars_next = {vars_reg.b, vars_reg.c, vars_reg.d, vars_reg.e,
                                 vars_reg.a};
                end
                if (cnt_reg == 3'(CV_DEPTH))
                begin
                    init_next = 1'b0;
                    if (final_reg)
                    begin
                        final_next = 1'b0;
                        state_next = ST_OUT_RD;
                        cnt_next   = 3'd0;
                    end
                    else if (pad_reg)
                    begin
                        state_next    = ST_PAD;
                        first_next    = 1'b0;
                        ptr_next      = 4'd0;
                        len_here_next = 1'b1;
                    end
                    else if (last_pend_reg)
                    begin
                        state_next    = ST_PAD;
                        pad_next      = 1'b1;
                        first_next    = 1'b1;
                        ptr_next      = total_reg[5:2];
                        len_here_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            ST_OUT_RD:
            begin
                state_next = ST_OUT_CAP;
            end

            ST_OUT_CAP:
            begin
                if (!out_valid_reg || digest_ready)
                begin
                    out_next.digest_word = cv_rdata_eff;
                    out_next.word_index  = cnt_reg;
                    out_next.last_digest = (cnt_reg == 3'(CV_DEPTH - 1));
                    out_valid_next       = 1'b1;
                    if (cnt_reg == 3'(CV_DEPTH - 1))
                    begin
                        state_next     = ST_IDLE;
                        init_next      = 1'b1;
                        total_next     = 61'd0;
                        cur_next       = 32'h0;
                        pad_next       = 1'b0;
                        last_pend_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            t_reg         <= 7'd0;
            total_reg     <= 61'd0;
            cur_reg       <= 32'h0;
            ptr_reg       <= 4'd0;
            first_reg     <= 1'b0;
            len_here_reg  <= 1'b0;
            final_reg     <= 1'b0;
            pad_reg       <= 1'b0;
            last_pend_reg <= 1'b0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            t_reg         <= t_next;
            total_reg     <= total_next;
            cur_reg       <= cur_next;
            ptr_reg       <= ptr_next;
            first_reg     <= first_next;
            len_here_reg  <= len_here_next;
            final_reg     <= final_next;
            pad_reg       <= pad_next;
            last_pend_reg <= last_pend_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers and schedule shift line.
    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        vars_reg       <= vars_next;
        out_reg        <= out_next;
        cv_raddr_q_reg <= cv_raddr;
        if (sched_push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= sched_w;
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

endmodule

// ===== sv/sha1he_ram.sv =====
// ----------------------------------------------------------------------------
// sha1he_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sha1he_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sha1he_round.sv =====
// ----------------------------------------------------------------------------
// sha1he_round
// One SHA-1 compression round: round function, constant and variable update.
// ----------------------------------------------------------------------------
module sha1he_round
    import sha1he_pkg::*;
(
    input  working_t   vars,
    input  round_ctl_t ctl,
    output working_t   vars_new
);

    logic [31:0] f;
    logic [31:0] k;

    // Round function and constant by round group.
    always_comb
    begin
        if (ctl.round < 7'd20)
        begin
            f = vars.d ^ (vars.b & (vars.c ^ vars.d));
            k = K0;
        end
        else if (ctl.round < 7'd40)
        begin
            f = vars.b ^ vars.c ^ vars.d;
            k = K1;
        end
        else if (ctl.round < 7'd60)
        begin
            f = (vars.b & vars.c) | (vars.d & (vars.b | vars.c));
            k = K2;
        end
        else
        begin
            f = vars.b ^ vars.c ^ vars.d;
            k = K3;
        end
    end

    // Variable rotation.
    always_comb
    begin
        vars_new.a = {vars.a[26:0], vars.a[31:27]} + f + vars.e + k + ctl.w;
        vars_new.b = vars.a;
        vars_new.c = {vars.b[1:0], vars.b[31:2]};
        vars_new.d = vars.c;
        vars_new.e = vars.d;
    end

endmodule

// ===== sv/sha1he_checker.sv =====
// ----------------------------------------------------------------------------
// sha1he_checker
// Port-level checks of the SHA-1 hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module sha1he_checker
    import sha1he_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic data_valid,
    input logic data_ready,
    input in_t  data,
    input logic digest_valid,
    input logic digest_ready,
    input out_t digest
);

    // A stalled digest beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
        else $error("digest beat changed while stalled");

    // A final input beat starts padding or, if it fills the block, the compression, so input stalls next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && data_ready && data.last_word |=> !data_ready)
        else $error("input taken during padding");

    // The closing flag marks exactly the fifth word.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_digest == (digest.word_index == 3'd4)))
        else $error("last digest flag mismatch");

    // Word index advances from zero to one after word zero is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest.last_digest && digest.word_index == 3'd0
        |=> !digest_valid || digest.word_index == 3'd1)
        else $error("digest word order broken");

endmodule

bind sha1_hash_engine sha1he_checker u_sha1he_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data         (data),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
);
